// ===== rtl/ray_affine_transform_4x4_top_assert.svh =====
// Assertion macros for the ray transform block.
// Expects clk and rst_n in the scope of each use.
`ifndef RAY_AFFINE_TRANSFORM_4X4_TOP_ASSERT_SVH
`define RAY_AFFINE_TRANSFORM_4X4_TOP_ASSERT_SVH
// same-cycle implication
`define RAT4_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RAT4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/rat4_pkg.sv =====
// Shared types and constants for the ray transform block.
// No dependencies.
package rat4_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int ENTRY_W         = 32;
  localparam int IO_W            = 32;
  localparam int NUM_CFG         = 8;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_SEL_W       = $clog2(NUM_CFG);
  localparam int CFG_W           = 64;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [IO_W-1:0] origin_x;
    logic signed [IO_W-1:0] origin_y;
    logic signed [IO_W-1:0] origin_z;
    logic signed [IO_W-1:0] dir_x;
    logic signed [IO_W-1:0] dir_y;
    logic signed [IO_W-1:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic signed [IO_W-1:0] new_origin_x;
    logic signed [IO_W-1:0] new_origin_y;
    logic signed [IO_W-1:0] new_origin_z;
    logic signed [IO_W-1:0] new_dir_x;
    logic signed [IO_W-1:0] new_dir_y;
    logic signed [IO_W-1:0] new_dir_z;
    logic                   w_zero;
    logic                   saturated;
  } ray_out_t;

  typedef struct packed {
    logic signed [IO_W-1:0] value;
    logic                   sat;
  } div_res_t;

  typedef struct packed {
    logic                   w_zero;
    logic                   dir_sat;
    logic signed [IO_W-1:0] dx;
    logic signed [IO_W-1:0] dy;
    logic signed [IO_W-1:0] dz;
  } side_t;

endpackage

// ===== rtl/rat4_div.sv =====
// Pipelined restoring divider: rounded Q16.16 quotient of magnitudes, one bit a stage.
// Depends on rat4_pkg.
module rat4_div import rat4_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int NW = CW + 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_i,
  input  logic [NW-1:0] d_i,
  input  logic          neg_i,
  output div_res_t      res_o
);

  localparam int RW = NW + FRAC_BITS;
  localparam int DW = NW + CW;
  localparam logic signed [CW+1:0] HI = {{3{1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] LO = {{3{1'b1}}, {(CW-1){1'b0}}};

  logic [RW-1:0] rem_r [CW+1];
  logic [NW-1:0] d_r   [CW+1];
  logic [CW-1:0] q_r   [CW+1];
  logic          neg_r [CW+1];
  logic          ovf_r [CW+1];

  logic [CW:0]   qr_r;
  logic          rneg_r;
  logic          rovf_r;
  div_res_t      res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {n_i, {FRAC_BITS{1'b0}}};
      d_r[0]   <= d_i;
      q_r[0]   <= '0;
      neg_r[0] <= neg_i;
      ovf_r[0] <= DW'(n_i) >= (DW'(d_i) << (CW - FRAC_BITS));
    end
  end

  for (genvar i = 0; i < CW; i++) begin : g_bit
    localparam int K = CW - 1 - i;
    logic [DW-1:0] dsh;
    logic [DW-1:0] remx;
    assign dsh  = DW'(d_r[i]) << K;
    assign remx = DW'(rem_r[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1]   <= d_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
        if (remx >= dsh) begin
          rem_r[i+1]  <= RW'(remx - dsh);
          q_r[i+1]    <= q_r[i] | (CW'(1) << K);
        end else begin
          rem_r[i+1]  <= rem_r[i];
          q_r[i+1]    <= q_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r   <= {1'b0, q_r[CW]} +
                (CW+1)'(((RW+1)'({rem_r[CW], 1'b0}) >= (RW+1)'(d_r[CW])));
      rneg_r <= neg_r[CW];
      rovf_r <= ovf_r[CW];
    end
  end

  logic signed [CW+1:0] sv;
  logic signed [CW-1:0] vcl;
  logic                 csat;

  always_comb begin
    sv = rneg_r ? -$signed({1'b0, qr_r}) : $signed({1'b0, qr_r});
    if (rovf_r) begin
      vcl  = rneg_r ? LO[CW-1:0] : HI[CW-1:0];
      csat = 1'b1;
    end else if (sv > HI) begin
      vcl  = HI[CW-1:0];
      csat = 1'b1;
    end else if (sv < LO) begin
      vcl  = LO[CW-1:0];
      csat = 1'b1;
    end else begin
      vcl  = sv[CW-1:0];
      csat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.value <= IO_W'(vcl);
      res_r.sat   <= csat;
    end
  end

  assign res_o = res_r;

endmodule

// ===== rtl/ray_affine_transform_4x4_top.sv =====
// Ray transform by a 4x4 matrix: origin as a point with divide by w, direction by 3x3.
// Depends on rat4_pkg, rat4_div and ray_affine_transform_4x4_top_assert.svh.
// Stages: operands, products, row sums, magnitudes, pipelined divider, output register.
// Throughput: one request per cycle; the whole pipeline holds while the output is stalled.
// Reset: synchronous active low; clears valid bits and loads the identity matrix.
module ray_affine_transform_4x4_top import rat4_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ray_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ray_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "ray_affine_transform_4x4_top_assert.svh"

  localparam int CW      = COORD_WIDTH;
  localparam int PW      = ENTRY_W + CW;
  localparam int SW      = PW + 2;
  localparam int NW      = SW - FRAC_BITS;
  localparam int DIV_LAT = CW + 3;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [NW-1:0] HI = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [NW-1:0] LO = {{(NW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic [CFG_W-1:0] cfg_r [NUM_CFG];
  logic signed [ENTRY_W-1:0] m [4][4];
  logic en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
      cfg_r[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      if (c % 2 == 1) begin : g_hi
        assign m[r][c] = cfg_r[2*r + c/2][63:32];
      end else begin : g_lo
        assign m[r][c] = cfg_r[2*r + c/2][31:0];
      end
    end
  end

  // stage 1: operands
  logic v1_r;
  logic signed [CW-1:0] o1_r [3];
  logic signed [CW-1:0] d1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1_r[0] <= in_data.origin_x[CW-1:0];
      o1_r[1] <= in_data.origin_y[CW-1:0];
      o1_r[2] <= in_data.origin_z[CW-1:0];
      d1_r[0] <= in_data.dir_x[CW-1:0];
      d1_r[1] <= in_data.dir_y[CW-1:0];
      d1_r[2] <= in_data.dir_z[CW-1:0];
    end
  end

  // stage 2: products
  logic v2_r;
  logic signed [PW-1:0] po_r [4][3];
  logic signed [PW-1:0] pd_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          po_r[r][c] <= m[r][c] * o1_r[c];
          if (r < 3) pd_r[r][c] <= m[r][c] * d1_r[c];
        end
      end
    end
  end

  // stage 3: row sums, rounded to 16 fraction bits, ties up
  logic v3_r;
  logic signed [NW-1:0] so_r [4];
  logic signed [NW-1:0] sd_r [3];
  logic signed [SW-1:0] so_sum [4];
  logic signed [SW-1:0] sd_sum [3];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      so_sum[r] = SW'(po_r[r][0]) + SW'(po_r[r][1]) + SW'(po_r[r][2])
                + (SW'(m[r][3]) <<< FRAC_BITS) + HALF;
    end
    for (int r = 0; r < 3; r++) begin
      sd_sum[r] = SW'(pd_r[r][0]) + SW'(pd_r[r][1]) + SW'(pd_r[r][2]) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) so_r[r] <= so_sum[r][SW-1:FRAC_BITS];
      for (int r = 0; r < 3; r++) sd_r[r] <= sd_sum[r][SW-1:FRAC_BITS];
    end
  end

  // stage 4: magnitudes and signs for the divide, direction clamp
  logic v4_r;
  logic [NW-1:0] nm4_r [3];
  logic          neg4_r [3];
  logic [NW-1:0] dm4_r;
  side_t         side4_r;
  logic signed [CW-1:0] dcl [3];
  logic [2:0]    dsat;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (sd_r[r] > HI) begin
        dcl[r]  = HI[CW-1:0];
        dsat[r] = 1'b1;
      end else if (sd_r[r] < LO) begin
        dcl[r]  = LO[CW-1:0];
        dsat[r] = 1'b1;
      end else begin
        dcl[r]  = sd_r[r][CW-1:0];
        dsat[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        nm4_r[r]  <= so_r[r][NW-1] ? NW'(-so_r[r]) : NW'(so_r[r]);
        neg4_r[r] <= so_r[r][NW-1] ^ so_r[3][NW-1];
      end
      dm4_r           <= so_r[3][NW-1] ? NW'(-so_r[3]) : NW'(so_r[3]);
      side4_r.w_zero  <= (so_r[3] == '0);
      side4_r.dir_sat <= |dsat;
      side4_r.dx      <= IO_W'(dcl[0]);
      side4_r.dy      <= IO_W'(dcl[1]);
      side4_r.dz      <= IO_W'(dcl[2]);
    end
  end

  // divide stages
  div_res_t dres [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rat4_div #(.CW(CW), .NW(NW)) u_div (
      .clk   (clk),
      .en    (en),
      .n_i   (nm4_r[i]),
      .d_i   (dm4_r),
      .neg_i (neg4_r[i]),
      .res_o (dres[i])
    );
  end

  logic  vd_r    [DIV_LAT];
  side_t sided_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_LAT; j++) vd_r[j] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v4_r;
      for (int j = 1; j < DIV_LAT; j++) vd_r[j] <= vd_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sided_r[0] <= side4_r;
      for (int j = 1; j < DIV_LAT; j++) sided_r[j] <= sided_r[j-1];
    end
  end

  // output register
  logic     out_valid_r;
  ray_out_t out_r;
  side_t    sl;

  assign sl = sided_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vd_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.new_origin_x <= sl.w_zero ? '0 : dres[0].value;
      out_r.new_origin_y <= sl.w_zero ? '0 : dres[1].value;
      out_r.new_origin_z <= sl.w_zero ? '0 : dres[2].value;
      out_r.new_dir_x    <= sl.dx;
      out_r.new_dir_y    <= sl.dy;
      out_r.new_dir_z    <= sl.dz;
      out_r.w_zero       <= sl.w_zero;
      out_r.saturated    <= sl.dir_sat ||
                            (!sl.w_zero && (dres[0].sat || dres[1].sat || dres[2].sat));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RAT4_ASSERT_SAME(a_wzero_origin, out_valid && out_data.w_zero,
    out_data.new_origin_x == '0 && out_data.new_origin_y == '0 &&
    out_data.new_origin_z == '0, "origin not zero with w_zero")
  `RAT4_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v1_r,
    "accepted request did not enter the pipeline")
  `RAT4_ASSERT_NEXT(a_stall_holds, !in_ready,
    $stable(v1_r) && $stable(v4_r) && out_valid_r,
    "pipeline moved while the output was stalled")

endmodule
